// ===== design/gwwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwb_pkg
// Shared types and constants of the gray-world white balance block.
// ----------------------------------------------------------------------------
package gwwb_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ACCUM   = 2'd1,
    OP_CORRECT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam int unsigned SumW  = 28;
  localparam int unsigned GainW = 24;
  localparam int unsigned ProdW = 32;
  localparam logic [GainW-1:0] GainOne = 24'd65536;
  localparam logic [GainW-1:0] GainMax = 24'hFFFFFF;

  // Request passed from the front part to the back part.
  typedef struct packed {
    logic       latch;
    logic [SumW-1:0] sum_b;
    logic [SumW-1:0] sum_g;
    logic [SumW-1:0] sum_r;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GAIN, ST_MUL, ST_NORM, ST_OUT
  } back_e;

endpackage

// ===== design/gwwb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwb_in_if / gwwb_out_if
// Valid/ready channels for input requests and balanced pixels.
// ----------------------------------------------------------------------------
interface gwwb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  modport source (output valid, operation, blue_in, green_in, red_in, input ready);
  modport sink (input valid, operation, blue_in, green_in, red_in, output ready);
endinterface

interface gwwb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  modport source (output valid, blue_out, green_out, red_out, input ready);
  modport sink (input valid, blue_out, green_out, red_out, output ready);
endinterface

// ===== design/gray_world_white_balance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_world_white_balance
// Gray-world white balance on BGR pixels with latched per-channel gains.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   operation, blue_in, green_in, red_in
// out_if    out  blue_out, green_out, red_out
//
// Clear and accumulate requests are handled in the front part. A correct request
// takes up to 3 divider runs for a gain update and 3 more when the largest channel
// needs normalizing, all on the one shared bit-serial divider.
// Reset clears sums and flags and sets unity gains; no clearing pass is needed.
// A stalled output holds its result; the front keeps accepting until its
// two-entry queue fills.
module gray_world_white_balance
  import gwwb_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic clk_i,
  input  logic rst_ni,
  gwwb_in_if.sink    in_if,
  gwwb_out_if.source out_if
);
  logic job_valid, job_ready;
  job_t job;

  gwwb_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk_i, .rst_ni, .in_if,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  gwwb_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job), .out_if
  );
endmodule

// ===== design/gwwb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gwwb_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one numerator bit and try a subtraction.
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign quo_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && (cnt_q == CntW'(1)) && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Done is registered and rises together with the complete quotient.
  assign done_o = done_q;
endmodule

// ===== design/gwwb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwb_front
// Decodes requests, keeps the channel sums and queues correct requests.
// ----------------------------------------------------------------------------
module gwwb_front
  import gwwb_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gwwb_in_if.sink in_if,
  output logic   job_valid_o,
  input  logic   job_ready_i,
  output job_t   job_o
);
  localparam longint unsigned CapRaw = longint'(MAX_PIXELS) * 255;
  localparam logic [SumW-1:0] SumCap =
    (CapRaw > 64'hFFFFFFF) ? 28'hFFFFFFF : SumW'(CapRaw);

  logic [SumW-1:0] sb_q, sg_q, sr_q;
  logic            latched_q;
  job_t            fifo_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            acc, push, pop;
  op_e             op;

  // A full queue stalls everything, which keeps the sums in step.
  assign in_if.ready = (cnt_q != 2'd2);
  assign acc  = in_if.valid && in_if.ready;
  assign op   = op_e'(in_if.operation);
  assign push = acc && (op == OP_CORRECT);
  assign pop  = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = fifo_q[rp_q];

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] s, logic [7:0] v);
    logic [SumW:0] r;
    r = {1'b0, s} + (SumW+1)'(v);
    return (r > {1'b0, SumCap}) ? SumCap : r[SumW-1:0];
  endfunction

  // Channel sums and the latched flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= '0; sg_q <= '0; sr_q <= '0;
      latched_q <= 1'b0;
    end else if (acc) begin
      unique case (op)
        OP_CLEAR: begin
          sb_q <= '0; sg_q <= '0; sr_q <= '0;
          latched_q <= 1'b0;
        end
        OP_ACCUM: begin
          sb_q <= sat_add(sb_q, in_if.blue_in);
          sg_q <= sat_add(sg_q, in_if.green_in);
          sr_q <= sat_add(sr_q, in_if.red_in);
          latched_q <= 1'b0;
        end
        OP_CORRECT: latched_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Two-entry queue toward the back part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{latch: !latched_q, sum_b: sb_q, sum_g: sg_q, sum_r: sr_q,
                        b: in_if.blue_in, g: in_if.green_in, r: in_if.red_in};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_sum_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_q <= SumCap && sg_q <= SumCap && sr_q <= SumCap) else $error("sum cap");
endmodule

// ===== design/gwwb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwb_back
// Computes gains when asked, then balances one pixel per request.
// ----------------------------------------------------------------------------
module gwwb_back
  import gwwb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  output logic    job_ready_o,
  input  job_t    job_i,
  gwwb_out_if.source out_if
);
  localparam int unsigned NumW = 48;
  localparam int unsigned DenW = 33;
  localparam logic [ProdW-1:0] Lim = 32'd255 << 16;

  back_e st_q, st_d;
  job_t  job_q;
  logic [GainW-1:0] gain_q [3];
  logic [ProdW-1:0] p_q [3];
  logic [ProdW-1:0] m_max;
  logic [7:0]  res_q [3];
  logic [1:0]  idx_q, idx_d;
  logic        dstart;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic        ddone;
  logic [NumW-1:0] quo;
  logic [SumW+1:0] total;
  logic [SumW-1:0] sel_sum;
  logic            out_v_q;

  assign total = (SumW+2)'(job_q.sum_b) + (SumW+2)'(job_q.sum_g) + (SumW+2)'(job_q.sum_r);
  always_comb begin
    unique case (idx_q)
      2'd0: sel_sum = job_q.sum_b;
      2'd1: sel_sum = job_q.sum_g;
      default: sel_sum = job_q.sum_r;
    endcase
  end

  // Largest product, taken straight from the registered products.
  always_comb begin
    logic [ProdW-1:0] mx;
    mx = (p_q[1] > p_q[0]) ? p_q[1] : p_q[0];
    m_max = (p_q[2] > mx) ? p_q[2] : mx;
  end

  // Divider operands: gain phase or normalize phase.
  always_comb begin
    logic [DenW-1:0] d3;
    d3 = DenW'(sel_sum) * DenW'(3);
    if (st_q == ST_GAIN) begin
      den = d3;
      num = NumW'({total, 16'd0}) + NumW'(d3 >> 1);
    end else begin
      den = {m_max, 1'b0};
      num = NumW'(p_q[idx_q]) * NumW'(510) + NumW'(m_max);
    end
  end

  gwwb_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(num), .den_i(den),
    .done_o(ddone), .quo_o(quo)
  );

  logic pending_q;
  assign job_ready_o = (st_q == ST_IDLE) && !out_v_q;
  assign out_if.valid     = out_v_q;
  assign out_if.blue_out  = res_q[0];
  assign out_if.green_out = res_q[1];
  assign out_if.red_out   = res_q[2];

  // Sequencer: gains, multiply, normalize, deliver.
  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    dstart = 1'b0;
    unique case (st_q)
      ST_IDLE: if (job_valid_i && job_ready_o) begin
        st_d  = job_i.latch ? ST_GAIN : ST_MUL;
        idx_d = '0;
      end
      ST_GAIN: begin
        if (sel_sum == '0) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 2'd2) st_d = ST_MUL;
        end else if (!pending_q) begin
          dstart = 1'b1;
        end else if (ddone) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 2'd2) st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        st_d  = ST_NORM;
        idx_d = '0;
      end
      ST_NORM: begin
        if (m_max <= Lim) st_d = ST_OUT;
        else if (!pending_q) dstart = 1'b1;
        else if (ddone) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 2'd2) st_d = ST_OUT;
        end
      end
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      idx_q <= '0;
      pending_q <= 1'b0;
      out_v_q <= 1'b0;
      gain_q[0] <= GainOne; gain_q[1] <= GainOne; gain_q[2] <= GainOne;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      if (dstart) pending_q <= 1'b1;
      else if (ddone) pending_q <= 1'b0;
      if (st_q == ST_OUT) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
      if (st_q == ST_GAIN) begin
        if (sel_sum == '0) gain_q[idx_q] <= GainOne;
        else if (ddone) gain_q[idx_q] <= (quo > NumW'(GainMax)) ? GainMax : quo[GainW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && job_valid_i && job_ready_o) job_q <= job_i;
    if (st_q == ST_MUL) begin
      p_q[0] <= ProdW'(job_q.b) * ProdW'(gain_q[0]);
      p_q[1] <= ProdW'(job_q.g) * ProdW'(gain_q[1]);
      p_q[2] <= ProdW'(job_q.r) * ProdW'(gain_q[2]);
    end
    if (st_q == ST_NORM) begin
      if (m_max <= Lim) begin
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= ((p_q[i] + 32'd32768) >> 16 > 32'd255) ? 8'd255
                      : 8'((p_q[i] + 32'd32768) >> 16);
        end
      end else if (ddone) begin
        res_q[idx_q] <= (quo > NumW'(255)) ? 8'd255 : quo[7:0];
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_if.ready |=> out_v_q) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> !job_ready_o) else $error("accepted while busy");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart |-> !pending_q) else $error("divider restarted");
endmodule

// ===== dv/tb_gray_world_white_balance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_world_white_balance
// Drives clear, accumulate and correct requests through the gray-world white
// balance block with random bursts and output stalls, predicts each balanced
// pixel with a bit-exact model of the gain and normalizing math, and compares
// every returned pixel in order against the oldest prediction.
// ----------------------------------------------------------------------------

// Scoreboard: tracks channel sums and latched gains, holds expected pixels.
class wb_scoreboard;
  localparam longint unsigned SumCap = 64'd267386880;
  longint unsigned sum_b, sum_g, sum_r;
  longint unsigned gain_b, gain_g, gain_r;
  bit latched;
  logic [23:0] pixel_q[$];
  int errors;

  function new();
    sum_b = 0; sum_g = 0; sum_r = 0;
    gain_b = 65536; gain_g = 65536; gain_r = 65536;
    latched = 0;
    errors = 0;
  endfunction

  function longint unsigned sat_add(longint unsigned s, longint unsigned v);
    longint unsigned r;
    r = s + v;
    return (r > SumCap) ? SumCap : r;
  endfunction

  function longint unsigned gain_of(longint unsigned total, longint unsigned s);
    longint unsigned den, g;
    if (s == 0) return 65536;
    den = 3 * s;
    g = ((total << 16) + den / 2) / den;
    return (g > 64'hFFFFFF) ? 64'hFFFFFF : g;
  endfunction

  function logic [7:0] scale(longint unsigned p, longint unsigned m);
    longint unsigned r;
    if (m > (64'd255 << 16)) r = (p * 255 * 2 + m) / (2 * m);
    else r = (p + 32768) >> 16;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Note an accepted request and queue the pixel it produces, if any.
  function void note_request(gwwb_pkg::op_e op, logic [7:0] b, logic [7:0] g,
                             logic [7:0] r);
    longint unsigned pb, pg, pr, m, total;
    case (op)
      gwwb_pkg::OP_CLEAR: begin
        sum_b = 0; sum_g = 0; sum_r = 0; latched = 0;
      end
      gwwb_pkg::OP_ACCUM: begin
        sum_b = sat_add(sum_b, b);
        sum_g = sat_add(sum_g, g);
        sum_r = sat_add(sum_r, r);
        latched = 0;
      end
      gwwb_pkg::OP_CORRECT: begin
        if (!latched) begin
          total = sum_b + sum_g + sum_r;
          gain_b = gain_of(total, sum_b);
          gain_g = gain_of(total, sum_g);
          gain_r = gain_of(total, sum_r);
          latched = 1;
        end
        pb = b * gain_b;
        pg = g * gain_g;
        pr = r * gain_r;
        m = pb;
        if (pg > m) m = pg;
        if (pr > m) m = pr;
        pixel_q.push_back({scale(pb, m), scale(pg, m), scale(pr, m)});
      end
      default: ;
    endcase
  endfunction

  // Compare a returned pixel with the oldest prediction.
  function void check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    logic [23:0] exp_px;
    if (pixel_q.size() == 0) begin
      $display("%0t: unexpected pixel b=%0d g=%0d r=%0d", $time, b, g, r);
      errors++;
      return;
    end
    exp_px = pixel_q.pop_front();
    if (b !== exp_px[23:16]) begin
      $display("%0t: blue expected %0d actual %0d", $time, exp_px[23:16], b);
      errors++;
    end
    if (g !== exp_px[15:8]) begin
      $display("%0t: green expected %0d actual %0d", $time, exp_px[15:8], g);
      errors++;
    end
    if (r !== exp_px[7:0]) begin
      $display("%0t: red expected %0d actual %0d", $time, exp_px[7:0], r);
      errors++;
    end
  endfunction
endclass

module tb_gray_world_white_balance;
  import gwwb_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  gwwb_in_if in_if ();
  gwwb_out_if out_if ();
  wb_scoreboard sb;
  int idle_cycles = 0;
  int gap_left;
  bit stall_on;

  gray_world_white_balance dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sends one request; a random gap may follow when a burst ends.
  task automatic send(op_e op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap_len;
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.blue_in <= b;
    in_if.green_in <= g;
    in_if.red_in <= r;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(op, b, g, r);
    if (gap_left > 0) begin
      gap_left--;
    end else begin
      gap_len = $urandom_range(0, 4) * $urandom_range(0, 1);
      if (gap_len > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      gap_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_pixel(op_e op);
    send(op, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // Output stall pattern: alternating stretches of free flow and random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_on <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      out_if.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Result check and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_pixel(out_if.blue_out, out_if.green_out, out_if.red_out);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("tb_gray_world_white_balance: errors");
        $finish;
      end
    end
  end

  initial begin
    int n;
    sb = new();
    gap_left = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_NONE;
    in_if.blue_in = '0;
    in_if.green_in = '0;
    in_if.red_in = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: correct with nothing accumulated, extremes, unused code, etc.
    send(OP_CORRECT, 8'd255, 8'd0, 8'd128);
    send(OP_CORRECT, 8'd0, 8'd0, 8'd0);
    send(OP_ACCUM, 8'd255, 8'd255, 8'd255);
    send(OP_CORRECT, 8'd255, 8'd255, 8'd255);
    send(OP_ACCUM, 8'd200, 8'd0, 8'd10);
    send(OP_CORRECT, 8'd255, 8'd255, 8'd255);
    send(OP_CORRECT, 8'd1, 8'd255, 8'd0);
    send(OP_NONE, 8'd255, 8'd255, 8'd255);
    send(OP_CORRECT, 8'd0, 8'd0, 8'd0);
    send(OP_CLEAR, 8'd170, 8'd85, 8'd255);
    send(OP_CORRECT, 8'd10, 8'd20, 8'd30);
    send(OP_ACCUM, 8'd1, 8'd0, 8'd0);
    send(OP_ACCUM, 8'd0, 8'd0, 8'd0);
    send(OP_CORRECT, 8'd255, 8'd255, 8'd255);
    send(OP_CORRECT, 8'd85, 8'd170, 8'd3);
    send(OP_ACCUM, 8'd0, 8'd1, 8'd255);
    send(OP_CORRECT, 8'd128, 8'd128, 8'd128);
    drain();

    // Random: mostly clear, accumulate a scene, correct pixels; some noise.
    n = 0;
    while (n < 1030) begin
      if ($urandom_range(0, 9) == 0) begin
        send(op_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
        n++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
          n++;
        end
        repeat ($urandom_range(1, 20)) begin
          send_pixel(OP_ACCUM);
          n++;
        end
        repeat ($urandom_range(1, 10)) begin
          send_pixel(OP_CORRECT);
          n++;
        end
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pixel_q.size() == 0)
      $display("tb_gray_world_white_balance: clean");
    else
      $display("tb_gray_world_white_balance: errors");
    $finish;
  end
endmodule
